### hw/rtl/ifsa_pkg.sv
package ifsa_pkg;

    localparam int unsigned TAG_W     = 8;
    localparam int unsigned DATA_W    = 48;
    localparam int unsigned MS_W      = 32;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned AXIS_W    = 16;
    localparam int unsigned PERIOD_W  = 12;
    localparam int unsigned KIND_W    = 5;

    localparam logic [KIND_W-1:0] KIND_GYRO  = 5'h01;
    localparam logic [KIND_W-1:0] KIND_ACCEL = 5'h02;
    localparam logic [KIND_W-1:0] KIND_STAMP = 5'h04;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd769;

    typedef struct packed {
        logic [TAG_W-1:0]  tag_byte;
        logic [DATA_W-1:0] payload;
        logic [MS_W-1:0]   uptime_ms;
    } t_in_item;

    typedef struct packed {
        logic [TICK_W-1:0]        stamp_ticks;
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic signed [AXIS_W-1:0] gyro_x;
        logic signed [AXIS_W-1:0] gyro_y;
        logic signed [AXIS_W-1:0] gyro_z;
        logic                     from_hardware;
    } t_sample;

    // multiply by 40 ticks per millisecond as two shifted adds, wraps at 32 bits
    function automatic logic [TICK_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
        logic [TICK_W-1:0] a;
        logic [TICK_W-1:0] b;
        a = {ms[TICK_W-6:0], 5'b0};
        b = {ms[TICK_W-4:0], 3'b0};
        return a + b;
    endfunction

endpackage

### hw/rtl/ifsa_in_if.sv
interface ifsa_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tag_byte;
    logic [47:0] payload;
    logic [31:0] uptime_ms;

    modport source (output valid, output tag_byte, output payload, output uptime_ms,
                    input ready);
    modport sink   (input valid, input tag_byte, input payload, input uptime_ms,
                    output ready);
endinterface

### hw/rtl/ifsa_out_if.sv
interface ifsa_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        stamp_ticks;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic               from_hardware;

    modport source (output valid, output stamp_ticks, output accel_x, output accel_y,
                    output accel_z, output gyro_x, output gyro_y, output gyro_z,
                    output from_hardware, input ready);
    modport sink   (input valid, input stamp_ticks, input accel_x, input accel_y,
                    input accel_z, input gyro_x, input gyro_y, input gyro_z,
                    input from_hardware, output ready);
endinterface

### hw/rtl/ifsa_core.sv
module ifsa_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  ifsa_pkg::t_in_item                 i_item,
    input  logic [ifsa_pkg::PERIOD_W-1:0]      i_period,
    input  logic                               i_cfg_we,
    output logic                               o_emit,
    output ifsa_pkg::t_sample                  o_sample
);
    import ifsa_pkg::*;

    logic [AXIS_W-1:0] r_accel [3];
    logic [AXIS_W-1:0] r_gyro  [3];
    logic [TICK_W-1:0] r_stamp;
    logic              r_have_accel;
    logic              r_have_gyro;
    logic              r_have_stamp;
    logic [TICK_W-1:0] r_counter;
    logic              r_seeded;

    logic [AXIS_W-1:0] n_accel [3];
    logic [AXIS_W-1:0] n_gyro  [3];
    logic [TICK_W-1:0] n_stamp;
    logic              n_have_accel;
    logic              n_have_gyro;
    logic              n_have_stamp;
    logic [TICK_W-1:0] n_counter;
    logic              n_seeded;

    logic [KIND_W-1:0] kind;
    logic [TICK_W-1:0] soft_base;
    logic [TICK_W-1:0] stamp;
    logic [TICK_W-1:0] period_ext;
    logic              hw_stamped;

    assign kind       = i_item.tag_byte[TAG_W-1:TAG_W-KIND_W];
    assign period_ext = {{(TICK_W-PERIOD_W){1'b0}}, i_period};

    always_comb begin
        n_accel      = r_accel;
        n_gyro       = r_gyro;
        n_stamp      = r_stamp;
        n_have_accel = r_have_accel;
        n_have_gyro  = r_have_gyro;
        n_have_stamp = r_have_stamp;
        n_counter    = r_counter;
        n_seeded     = r_seeded;

        // store the word by type
        case (kind)
            KIND_ACCEL: begin
                for (int k = 0; k < 3; k++) begin
                    n_accel[k] = i_item.payload[k*AXIS_W +: AXIS_W];
                end
                n_have_accel = 1'b1;
            end
            KIND_GYRO: begin
                for (int k = 0; k < 3; k++) begin
                    n_gyro[k] = i_item.payload[k*AXIS_W +: AXIS_W];
                end
                n_have_gyro = 1'b1;
            end
            KIND_STAMP: begin
                n_stamp      = i_item.payload[TICK_W-1:0];
                n_have_stamp = 1'b1;
            end
            default: begin
            end
        endcase

        o_emit = n_have_accel && n_have_gyro;

        // software base: seed from uptime on first use
        soft_base  = r_seeded ? r_counter : ms_to_ticks(i_item.uptime_ms);
        hw_stamped = n_have_stamp;
        stamp      = hw_stamped ? n_stamp : soft_base;

        if (o_emit) begin
            n_counter    = stamp + period_ext;
            n_seeded     = 1'b1;
            n_have_accel = 1'b0;
            n_have_gyro  = 1'b0;
            n_have_stamp = 1'b0;
        end

        o_sample.stamp_ticks   = stamp;
        o_sample.accel_x       = n_accel[0];
        o_sample.accel_y       = n_accel[1];
        o_sample.accel_z       = n_accel[2];
        o_sample.gyro_x        = n_gyro[0];
        o_sample.gyro_y        = n_gyro[1];
        o_sample.gyro_z        = n_gyro[2];
        o_sample.from_hardware = hw_stamped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_accel[k] <= '0;
                r_gyro[k]  <= '0;
            end
            r_stamp      <= '0;
            r_have_accel <= 1'b0;
            r_have_gyro  <= 1'b0;
            r_have_stamp <= 1'b0;
            r_counter    <= '0;
            r_seeded     <= 1'b0;
        end else begin
            if (i_adv) begin
                r_accel      <= n_accel;
                r_gyro       <= n_gyro;
                r_stamp      <= n_stamp;
                r_have_accel <= n_have_accel;
                r_have_gyro  <= n_have_gyro;
                r_have_stamp <= n_have_stamp;
                r_counter    <= n_counter;
            end
            // period write forces a reseed
            if (i_cfg_we) begin
                r_seeded <= 1'b0;
            end else if (i_adv) begin
                r_seeded <= n_seeded;
            end
        end
    end

endmodule

### hw/rtl/imu_fifo_sample_assembler_top.sv
// channel  dir  modport  beat contents
// i_in     in   sink     tag_byte, payload, uptime_ms
// o_out    out  source   stamp_ticks, accel/gyro x y z, from_hardware
// cfg      in   -        i_cfg_we, i_cfg_wdata (period_ticks)
//
// one beat per cycle sustained unless output stalls; samples exit the result register
// the rate is set by the input register feeding the assembler in one pass
// reset is synchronous, active low: presence and seed flags clear, period goes to 769
// a stalled output holds its sample; the input register still drains into a
// free output slot, so in ready only drops when both stages are full
module imu_fifo_sample_assembler_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ifsa_in_if.sink                       i_in,
    ifsa_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [ifsa_pkg::PERIOD_W-1:0] i_cfg_wdata
);
    import ifsa_pkg::*;

    // input register stage
    logic     r_in_valid;
    t_in_item r_in_item;

    // result register stage
    logic     r_out_valid;
    t_sample  r_out;

    // period register
    logic [PERIOD_W-1:0] r_period;

    logic    adv;
    logic    emit;
    t_sample sample;

    // the held word moves on when the result slot is free or being emptied
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    ifsa_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in_item),
        .i_period (r_period),
        .i_cfg_we (i_cfg_we),
        .o_emit   (emit),
        .o_sample (sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= PERIOD_RESET;
        end else begin
            // capture a beat when the input stage is free or draining
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            // result slot: load on emission, clear when taken
            if (adv && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item.tag_byte  <= i_in.tag_byte;
            r_in_item.payload   <= i_in.payload;
            r_in_item.uptime_ms <= i_in.uptime_ms;
        end
        if (adv && emit) begin
            r_out <= sample;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.stamp_ticks   = r_out.stamp_ticks;
    assign o_out.accel_x       = r_out.accel_x;
    assign o_out.accel_y       = r_out.accel_y;
    assign o_out.accel_z       = r_out.accel_z;
    assign o_out.gyro_x        = r_out.gyro_x;
    assign o_out.gyro_y        = r_out.gyro_y;
    assign o_out.gyro_z        = r_out.gyro_z;
    assign o_out.from_hardware = r_out.from_hardware;

endmodule

### dv/ifsa_sample_checker.sv
module ifsa_sample_checker
    import ifsa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    ifsa_in_if                  i_words,
    ifsa_out_if                 i_samples,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_waiting,
    output int                  o_sample_count,
    output int                  o_hw_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [TICK_W-1:0] TICKS_PER_MS = 32'd40;

    // mirror of the assembler state
    logic [PERIOD_W-1:0] period;
    logic [AXIS_W-1:0]   accel_axes [3];
    logic [AXIS_W-1:0]   gyro_axes [3];
    logic [TICK_W-1:0]   hw_stamp;
    logic                accel_seen;
    logic                gyro_seen;
    logic                stamp_seen;
    logic [TICK_W-1:0]   tick_counter;
    logic                counter_live;

    t_sample pending_samples [$];

    // fold one word into the held state, queue a sample once accel and gyro are both held
    task automatic assemble_from_word(input t_in_item w);
        logic [KIND_W-1:0] kind;
        t_sample s;
        kind = w.tag_byte[TAG_W-1:TAG_W-KIND_W];
        if (kind == KIND_ACCEL) begin
            for (int i = 0; i < 3; i++) accel_axes[i] = w.payload[AXIS_W*i +: AXIS_W];
            accel_seen = 1'b1;
        end else if (kind == KIND_GYRO) begin
            for (int i = 0; i < 3; i++) gyro_axes[i] = w.payload[AXIS_W*i +: AXIS_W];
            gyro_seen = 1'b1;
        end else if (kind == KIND_STAMP) begin
            hw_stamp   = w.payload[TICK_W-1:0];
            stamp_seen = 1'b1;
        end
        if (accel_seen && gyro_seen) begin
            if (stamp_seen) begin
                s.stamp_ticks   = hw_stamp;
                tick_counter    = hw_stamp + TICK_W'(period);
                counter_live    = 1'b1;
                s.from_hardware = 1'b1;
            end else begin
                if (!counter_live) begin
                    tick_counter = w.uptime_ms * TICKS_PER_MS;
                    counter_live = 1'b1;
                end
                s.stamp_ticks   = tick_counter;
                tick_counter    = tick_counter + TICK_W'(period);
                s.from_hardware = 1'b0;
            end
            s.accel_x = accel_axes[0];
            s.accel_y = accel_axes[1];
            s.accel_z = accel_axes[2];
            s.gyro_x  = gyro_axes[0];
            s.gyro_y  = gyro_axes[1];
            s.gyro_z  = gyro_axes[2];
            pending_samples.push_back(s);
            accel_seen = 1'b0;
            gyro_seen  = 1'b0;
            stamp_seen = 1'b0;
        end
    endtask

    function automatic void check_field(input string field, input logic [TICK_W-1:0] want,
                                        input logic [TICK_W-1:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_in_item word;
        t_sample  got;
        t_sample  want;
        if (!i_rst_n) begin
            period = PERIOD_RESET;
            for (int i = 0; i < 3; i++) begin
                accel_axes[i] = '0;
                gyro_axes[i]  = '0;
            end
            hw_stamp     = '0;
            accel_seen   = 1'b0;
            gyro_seen    = 1'b0;
            stamp_seen   = 1'b0;
            tick_counter = '0;
            counter_live = 1'b0;
            pending_samples.delete();
        end else begin
            if (i_samples.valid && i_samples.ready) begin
                got.stamp_ticks   = i_samples.stamp_ticks;
                got.accel_x       = i_samples.accel_x;
                got.accel_y       = i_samples.accel_y;
                got.accel_z       = i_samples.accel_z;
                got.gyro_x        = i_samples.gyro_x;
                got.gyro_y        = i_samples.gyro_y;
                got.gyro_z        = i_samples.gyro_z;
                got.from_hardware = i_samples.from_hardware;
                if (pending_samples.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: sample beat with none expected, got %h", $time, got);
                end else begin
                    want = pending_samples.pop_front();
                    o_sample_count++;
                    if (want.from_hardware) o_hw_count++;
                    check_field("stamp_ticks", want.stamp_ticks, got.stamp_ticks);
                    check_field("accel_x", TICK_W'($unsigned(want.accel_x)),
                                TICK_W'($unsigned(got.accel_x)));
                    check_field("accel_y", TICK_W'($unsigned(want.accel_y)),
                                TICK_W'($unsigned(got.accel_y)));
                    check_field("accel_z", TICK_W'($unsigned(want.accel_z)),
                                TICK_W'($unsigned(got.accel_z)));
                    check_field("gyro_x", TICK_W'($unsigned(want.gyro_x)),
                                TICK_W'($unsigned(got.gyro_x)));
                    check_field("gyro_y", TICK_W'($unsigned(want.gyro_y)),
                                TICK_W'($unsigned(got.gyro_y)));
                    check_field("gyro_z", TICK_W'($unsigned(want.gyro_z)),
                                TICK_W'($unsigned(got.gyro_z)));
                    check_field("from_hardware", TICK_W'(want.from_hardware),
                                TICK_W'(got.from_hardware));
                end
            end
            if (i_cfg_we) begin
                period       = i_cfg_wdata;
                counter_live = 1'b0;
            end
            if (i_words.valid && i_words.ready) begin
                word.tag_byte  = i_words.tag_byte;
                word.payload   = i_words.payload;
                word.uptime_ms = i_words.uptime_ms;
                assemble_from_word(word);
            end
        end
        o_waiting = pending_samples.size();
    end

endmodule

### dv/tb_imu_fifo_sample_assembler_top.sv
module tb_imu_fifo_sample_assembler_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ifsa_pkg::*;

    // tag kinds the assembler has no use for
    localparam logic [KIND_W-1:0] KIND_UNUSED_00 = 5'h00;
    localparam logic [KIND_W-1:0] KIND_UNUSED_03 = 5'h03;
    localparam logic [KIND_W-1:0] KIND_UNUSED_05 = 5'h05;
    localparam logic [KIND_W-1:0] KIND_UNUSED_1F = 5'h1F;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;     // margin after the last word for the input and result registers to empty
    localparam int WORDS_PER_PHASE = 280;   // five phases, about 1400 useful words
    localparam int STEADY_WORDS    = 160;   // stretch of phase 2 with no idling on either side

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [PERIOD_W-1:0] cfg_wdata;

    logic steady = 1'b0;
    int   cycle_count = 0;
    int   words_sent = 0;
    int   known_words = 0;
    int   fail_count;
    int   waiting;
    int   samples_checked;
    int   hw_samples;

    logic [PERIOD_W-1:0] plan [5];

    ifsa_in_if  word_ch ();
    ifsa_out_if sample_ch ();

    imu_fifo_sample_assembler_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (word_ch),
        .o_out       (sample_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // watches both channels and the period writes, predicts and compares
    ifsa_sample_checker u_sample_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_words        (word_ch),
        .i_samples      (sample_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .o_fail_count   (fail_count),
        .o_waiting      (waiting),
        .o_sample_count (samples_checked),
        .o_hw_count     (hw_samples)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // sample side back-pressure, about 13 stalls in a hundred outside the steady stretch
    always @(posedge clk) begin
        sample_ch.ready <= steady || ($urandom_range(99) >= 13);
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d samples still owed", cycle_count, waiting);
        $display("tb_imu_fifo_sample_assembler_top: errors");
        $finish;
    end

    function automatic t_in_item make_word(input logic [KIND_W-1:0] kind,
                                           input logic [2:0] low_bits,
                                           input logic [DATA_W-1:0] data,
                                           input logic [MS_W-1:0] uptime);
        t_in_item w;
        w.tag_byte  = {kind, low_bits};
        w.payload   = data;
        w.uptime_ms = uptime;
        return w;
    endfunction

    // uptime only matters when the counter seeds; lean on the edges now and then
    function automatic logic [MS_W-1:0] pick_uptime();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return MS_W'($urandom_range(1000));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [AXIS_W-1:0] pick_axis();
        case ($urandom_range(3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic t_in_item axis_word(input logic [KIND_W-1:0] kind);
        logic [DATA_W-1:0] data;
        if ($urandom_range(9) == 0) data = {pick_axis(), pick_axis(), pick_axis()};
        else data = {16'($urandom), 32'($urandom)};
        return make_word(kind, 3'($urandom), data, pick_uptime());
    endfunction

    // some stamps sit just under the wrap so stamp + period rolls over
    function automatic t_in_item stamp_word();
        logic [DATA_W-1:0] data;
        if ($urandom_range(7) == 0)
            data = {16'($urandom), 32'hFFFF_FFFF - 32'($urandom_range(4095))};
        else data = {16'($urandom), 32'($urandom)};
        return make_word(KIND_STAMP, 3'($urandom), data, pick_uptime());
    endfunction

    // one word beat; valid stays up into the next word unless an idle cycle is drawn
    task automatic send_word(input t_in_item w);
        logic [KIND_W-1:0] kind;
        kind = w.tag_byte[TAG_W-1:TAG_W-KIND_W];
        while (!steady && $urandom_range(99) < 13) begin
            word_ch.valid <= 1'b0;
            @(posedge clk);
        end
        word_ch.valid     <= 1'b1;
        word_ch.tag_byte  <= w.tag_byte;
        word_ch.payload   <= w.payload;
        word_ch.uptime_ms <= w.uptime_ms;
        @(posedge clk);
        while (!word_ch.ready) @(posedge clk);
        words_sent++;
        if (kind == KIND_ACCEL || kind == KIND_GYRO || kind == KIND_STAMP) known_words++;
    endtask

    // stop sending and wait for every owed sample
    task automatic drain_samples();
        word_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
    endtask

    // period writes only land on an idle block
    task automatic set_period(input logic [PERIOD_W-1:0] value);
        drain_samples();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly complete accel/gyro pairs, with noise and broken sequences mixed in
    task automatic send_random_burst();
        int unsigned       pick;
        int unsigned       stamp_at;
        logic [KIND_W-1:0] first_kind;
        logic [KIND_W-1:0] second_kind;
        logic [KIND_W-1:0] odd_kind;
        pick = $urandom_range(99);
        if (pick < 75) begin
            // stamp lands before, between or after the pair, or not at all
            first_kind  = $urandom_range(1) ? KIND_ACCEL : KIND_GYRO;
            second_kind = (first_kind == KIND_ACCEL) ? KIND_GYRO : KIND_ACCEL;
            stamp_at    = $urandom_range(5);
            if (stamp_at == 3) send_word(stamp_word());
            send_word(axis_word(first_kind));
            if (stamp_at == 4) send_word(stamp_word());
            send_word(axis_word(second_kind));
            if (stamp_at == 5) send_word(stamp_word());
        end else if (pick < 85) begin
            // unused tag, must leave the held state alone
            do odd_kind = KIND_W'($urandom);
            while (odd_kind == KIND_ACCEL || odd_kind == KIND_GYRO || odd_kind == KIND_STAMP);
            send_word(make_word(odd_kind, 3'($urandom), {16'($urandom), 32'($urandom)},
                                $urandom));
        end else if (pick < 93) begin
            // same sensor twice, newer word overwrites
            first_kind = $urandom_range(1) ? KIND_ACCEL : KIND_GYRO;
            send_word(axis_word(first_kind));
            send_word(axis_word(first_kind));
        end else begin
            send_word(stamp_word());
        end
    endtask

    initial begin
        // every input known from time zero, sample ready settles at the first edge
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        word_ch.valid       = 1'b0;
        word_ch.tag_byte    = '0;
        word_ch.payload     = '0;
        word_ch.uptime_ms   = '0;

        plan[0] = 12'd0;
        plan[1] = 12'hFFF;
        plan[2] = 12'd1;
        plan[3] = PERIOD_W'($urandom_range(4094, 2));
        plan[4] = PERIOD_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed words at the reset period, counter not yet seeded
        send_word(make_word(KIND_UNUSED_00, 3'd0, 48'hFFFF_FFFF_FFFF, 32'd0));
        // gyro then accel, seed from max uptime wraps the counter
        send_word(make_word(KIND_GYRO, 3'd7, 48'hFFFF_FFFF_FFFF, 32'd0));
        send_word(make_word(KIND_ACCEL, 3'd0, 48'h7FFF_8000_0001, 32'hFFFF_FFFF));
        // accel overwritten before the gyro shows up
        send_word(make_word(KIND_ACCEL, 3'd2, 48'h0000_0000_0000, 32'd5));
        send_word(make_word(KIND_ACCEL, 3'd5, 48'h8000_7FFF_FFFF, 32'd6));
        send_word(make_word(KIND_GYRO, 3'd1, 48'h0001_0002_0003, 32'd12345));
        // hardware stamp at the top, stamp plus period wraps, upper payload ignored
        send_word(make_word(KIND_STAMP, 3'd3, 48'hFFFF_FFFF_FFFF, 32'd0));
        send_word(make_word(KIND_GYRO, 3'd4, 48'h1234_5678_9ABC, 32'd0));
        send_word(make_word(KIND_ACCEL, 3'd6, 48'hFEDC_BA98_7654, 32'd0));
        // soft counter carries on from the resync
        send_word(make_word(KIND_ACCEL, 3'd0, 48'h5555_AAAA_5555, 32'd77));
        send_word(make_word(KIND_GYRO, 3'd0, 48'hAAAA_5555_AAAA, 32'd78));
        send_word(make_word(KIND_ACCEL, 3'd1, 48'h0F0F_F0F0_0F0F, 32'd79));
        send_word(make_word(KIND_GYRO, 3'd2, 48'hF0F0_0F0F_F0F0, 32'd80));
        // stamp after the pair is held for the next one, unused tag in between
        send_word(make_word(KIND_STAMP, 3'd0, 48'h0000_DEAD_BEEF, 32'd0));
        send_word(make_word(KIND_UNUSED_1F, 3'd7, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        send_word(make_word(KIND_GYRO, 3'd3, 48'h0000_FFFF_0000, 32'd0));
        send_word(make_word(KIND_ACCEL, 3'd4, 48'hFFFF_0000_FFFF, 32'd0));
        // second stamp overwrites the first
        send_word(make_word(KIND_STAMP, 3'd1, 48'h0000_0000_0000, 32'd0));
        send_word(make_word(KIND_STAMP, 3'd6, 48'hABCD_1234_5678, 32'd0));
        send_word(make_word(KIND_ACCEL, 3'd7, 48'h8000_8000_8000, 32'd0));
        send_word(make_word(KIND_GYRO, 3'd5, 48'h7FFF_7FFF_7FFF, 32'd0));
        send_word(make_word(KIND_UNUSED_03, 3'd2, 48'h0123_4567_89AB, 32'd9));
        send_word(make_word(KIND_UNUSED_05, 3'd5, 48'hBA98_7654_3210, 32'd10));

        // random phases, each period write forces a reseed from uptime
        for (int ph = 0; ph < 5; ph++) begin
            int phase_start;
            set_period(plan[ph]);
            phase_start = known_words;
            while (known_words - phase_start < WORDS_PER_PHASE) begin
                steady = (ph == 2) && (known_words - phase_start < STEADY_WORDS);
                send_random_burst();
            end
            steady = 1'b0;
        end

        drain_samples();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d word beats (%0d with unused tags) at periods 769 0 4095 1 %0d 769",
                 words_sent, words_sent - known_words, plan[3]);
        $display("checked %0d samples, %0d hardware stamped, %0d mismatches",
                 samples_checked, hw_samples, fail_count);
        if (fail_count == 0) begin
            $display("tb_imu_fifo_sample_assembler_top: clean");
        end else begin
            $display("tb_imu_fifo_sample_assembler_top: errors");
        end
        $finish;
    end

endmodule
